// ===== hdl/mmel_pkg.sv =====
// ----------------------------------------------------------------------------
// Expression lexer package
// Shared types and constants for the maximal-munch expression lexer.
// ----------------------------------------------------------------------------
package mmel_pkg;

   // Default for the line length that sets the column and length limits.
   localparam int MAX_LINE_DEFAULT = 1024;

   // Result field widths.
   localparam int KIND_W  = 3;
   localparam int COL_W   = 10;
   localparam int LEN_W   = 11;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Character codes that the classifier looks for.
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   typedef enum logic [KIND_W-1:0] {
      KIND_NUMBER  = 3'd0,
      KIND_IDENT   = 3'd1,
      KIND_SYMBOL  = 3'd2,
      KIND_UNKNOWN = 3'd3,
      KIND_NONE    = 3'd4
   } kind_type;

   // Character classes found by the front.
   typedef struct packed {
      logic is_digit;
      logic is_alpha;
      logic is_under;
      logic is_period;
      logic is_space;
      logic is_sym;
      logic is_hash;
   } char_class_type;

   // One queued item: a classified character or an end-of-line marker.
   typedef struct packed {
      char_class_type cls;
      logic           end_of_line;
   } queue_entry_type;

endpackage

// ===== hdl/mmel_req_if.sv =====
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that carries one character byte or an end-of-line mark.
// ----------------------------------------------------------------------------
interface mmel_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_line;

   modport source (output valid, output ch, output end_of_line, input ready);
   modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

// ===== hdl/mmel_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel that carries one token descriptor.
// ----------------------------------------------------------------------------
interface mmel_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [9:0]  start_column;
   logic [10:0] length;
   logic        line_done;

   modport source (output valid, output kind, output start_column, output length,
                   output line_done, input ready);
   modport sink   (input valid, input kind, input start_column, input length,
                   input line_done, output ready);
endinterface

// ===== hdl/max_munch_expression_lexer.sv =====
// ----------------------------------------------------------------------------
// Maximal-munch expression lexer
// Splits a character stream into number, identifier, symbol and unknown tokens.
// ----------------------------------------------------------------------------
// The lexer takes one character transfer per clock cycle while the queue has
// room, and returns one token descriptor (kind, start column, length and a
// line-done flag) each time a token ends, with exactly one descriptor for every
// end-of-line marker, which carries the token that the marker ends or kind none.
// A result passes through the two-entry queue, into which the byte is
// classified, and then the output register, into which the token state
// update lands. The token state update in the back end is the one loop that
// sets the rate, so the sustained rate is one character per cycle for as
// long as results are taken. While the result side stalls, the queue keeps
// taking characters until it holds two, and the output register keeps one
// finished result waiting. There is no clearing pass after reset.
module max_munch_expression_lexer #(
   parameter int MAX_LINE = mmel_pkg::MAX_LINE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mmel_req_if.sink   req,
   mmel_rsp_if.source rsp
);
   import mmel_pkg::*;

   // Front to queue.
   logic            push;
   queue_entry_type push_entry;
   logic            queue_full;

   // Queue to back.
   logic            head_valid;
   queue_entry_type head_entry;
   logic            pop;

   // The front classifies every byte as it is accepted, so the back only
   // sees a handful of class flags and never the byte itself.
   mmel_front u_front (
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // The queue lets the input side keep running until it holds two items
   // while the result side is stalled.
   mmel_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // The back holds the pending token and the column, and decides for each
   // item whether it extends the token or ends it.
   mmel_back #(
      .MAX_LINE (MAX_LINE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

// ===== hdl/mmel_front.sv =====
// ----------------------------------------------------------------------------
// Lexer front end
// Takes character transfers and classifies each byte for the queue.
// ----------------------------------------------------------------------------
module mmel_front (
   mmel_req_if.sink                 req,
   input  logic                     queue_full,
   output logic                     push,
   output mmel_pkg::queue_entry_type push_entry
);
   import mmel_pkg::*;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cls;
      cls.is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      cls.is_alpha  = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
                      ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
      cls.is_under  = (c == CHAR_UNDER);
      cls.is_period = (c == CHAR_PERIOD);
      cls.is_space  = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE);
      cls.is_sym    = (c == CHAR_LPAREN) || (c == CHAR_RPAREN) || (c == CHAR_PLUS) ||
                      (c == CHAR_MINUS) || (c == CHAR_STAR) || (c == CHAR_SLASH);
      cls.is_hash   = (c == CHAR_HASH);
      return cls;
   endfunction

   assign req.ready              = !queue_full;
   assign push                   = req.valid && !queue_full;
   assign push_entry.cls         = classify(req.ch);
   assign push_entry.end_of_line = req.end_of_line;

endmodule

// ===== hdl/mmel_queue.sv =====
// ----------------------------------------------------------------------------
// Lexer queue
// Short FIFO of classified characters between the front and the back.
// ----------------------------------------------------------------------------
module mmel_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mmel_pkg::queue_entry_type push_entry,
   output logic                      full,
   output logic                      head_valid,
   output mmel_pkg::queue_entry_type head_entry,
   input  logic                      pop
);
   import mmel_pkg::*;

   queue_entry_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/mmel_back.sv =====
// ----------------------------------------------------------------------------
// Lexer back end
// Runs the token state for each queued item and registers the results.
// ----------------------------------------------------------------------------
module mmel_back #(
   parameter int MAX_LINE = mmel_pkg::MAX_LINE_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  mmel_pkg::queue_entry_type head_entry,
   output logic                      pop,
   mmel_rsp_if.source                rsp
);
   import mmel_pkg::*;

   localparam int COL_CAP_INT = ((MAX_LINE - 1) < 1023) ? (MAX_LINE - 1) : 1023;
   localparam int LEN_CAP_INT = (MAX_LINE < 2047) ? MAX_LINE : 2047;
   localparam logic [COL_W-1:0] COL_CAP = COL_W'(COL_CAP_INT);
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

   // Token state.
   logic             may_num_ff, may_num_in;
   logic             may_id_ff, may_id_in;
   logic             seen_period_ff, seen_period_in;
   logic             sym_ff, sym_in;
   logic             unk_ff, unk_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [COL_W-1:0] start_ff, start_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic             in_comment_ff, in_comment_in;

   // Output register.
   logic             out_valid_ff, out_valid_in;
   kind_type         kind_ff, kind_in;
   logic [COL_W-1:0] out_start_ff, out_start_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;
   logic             done_ff, done_in;

   char_class_type   cls;
   logic             num_ok, id_ok, extend, emit;
   kind_type         cur_kind;

   assign cls = head_entry.cls;
   assign pop = head_valid && (!out_valid_ff || rsp.ready);

   always_comb begin
      priority if (may_id_ff) begin
         cur_kind = KIND_IDENT;
      end else if (may_num_ff) begin
         cur_kind = KIND_NUMBER;
      end else if (sym_ff) begin
         cur_kind = KIND_SYMBOL;
      end else begin
         cur_kind = KIND_UNKNOWN;
      end
   end

   assign num_ok = may_num_ff &&
                   (cls.is_digit || cls.is_under || (cls.is_period && !seen_period_ff));
   assign id_ok  = may_id_ff && (cls.is_alpha || cls.is_digit || cls.is_under);
   assign extend = (len_ff != '0) && !cls.is_space && !sym_ff && !unk_ff &&
                   (num_ok || id_ok);

   always_comb begin
      may_num_in     = may_num_ff;
      may_id_in      = may_id_ff;
      seen_period_in = seen_period_ff;
      sym_in         = sym_ff;
      unk_in         = unk_ff;
      len_in         = len_ff;
      start_in       = start_ff;
      column_in      = column_ff;
      in_comment_in  = in_comment_ff;
      emit           = 1'b0;
      kind_in        = cur_kind;
      out_start_in   = start_ff;
      out_len_in     = len_ff;
      done_in        = 1'b0;

      if (head_entry.end_of_line) begin
         // Flush whatever is pending and start the next line clean.
         emit = 1'b1;
         done_in = 1'b1;
         if (len_ff == '0) begin
            kind_in      = KIND_NONE;
            out_start_in = '0;
            out_len_in   = '0;
         end
         may_num_in     = 1'b0;
         may_id_in      = 1'b0;
         seen_period_in = 1'b0;
         sym_in         = 1'b0;
         unk_in         = 1'b0;
         len_in         = '0;
         start_in       = '0;
         column_in      = '0;
         in_comment_in  = 1'b0;
      end else if (in_comment_ff) begin
         // Comment text is dropped and does not move the column.
      end else if (cls.is_hash) begin
         in_comment_in = 1'b1;
      end else begin
         if (extend) begin
            may_num_in = num_ok;
            may_id_in  = id_ok;
            if (num_ok && cls.is_period) begin
               seen_period_in = 1'b1;
            end
            if (len_ff < LEN_CAP) begin
               len_in = len_ff + 1'b1;
            end
         end else begin
            emit = (len_ff != '0);
            if (cls.is_space) begin
               may_num_in     = 1'b0;
               may_id_in      = 1'b0;
               seen_period_in = 1'b0;
               sym_in         = 1'b0;
               unk_in         = 1'b0;
               len_in         = '0;
               start_in       = '0;
            end else begin
               may_num_in     = cls.is_digit || cls.is_under || cls.is_period;
               seen_period_in = cls.is_period;
               may_id_in      = cls.is_alpha || cls.is_under;
               sym_in         = cls.is_sym;
               unk_in         = !(cls.is_digit || cls.is_under || cls.is_period ||
                                  cls.is_alpha || cls.is_sym);
               len_in         = LEN_W'(1);
               start_in       = column_ff;
            end
         end
         if (column_ff < COL_CAP) begin
            column_in = column_ff + 1'b1;
         end
      end

      out_valid_in = out_valid_ff && !rsp.ready;
      if (pop && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         may_num_ff     <= 1'b0;
         may_id_ff      <= 1'b0;
         seen_period_ff <= 1'b0;
         sym_ff         <= 1'b0;
         unk_ff         <= 1'b0;
         len_ff         <= '0;
         start_ff       <= '0;
         column_ff      <= '0;
         in_comment_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            may_num_ff     <= may_num_in;
            may_id_ff      <= may_id_in;
            seen_period_ff <= seen_period_in;
            sym_ff         <= sym_in;
            unk_ff         <= unk_in;
            len_ff         <= len_in;
            start_ff       <= start_in;
            column_ff      <= column_in;
            in_comment_ff  <= in_comment_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         kind_ff      <= kind_in;
         out_start_ff <= out_start_in;
         out_len_ff   <= out_len_in;
         done_ff      <= done_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = kind_ff;
   assign rsp.start_column = out_start_ff;
   assign rsp.length       = out_len_ff;
   assign rsp.line_done    = done_ff;

   // An end-of-line marker leaves the token state and the column cleared.
   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head_entry.end_of_line) |=>
         (len_ff == '0) && (column_ff == '0) && !in_comment_ff)
      else $error("state not cleared after end of line");

   // A pending length exists exactly when some token class is live.
   a_len_class: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) == (may_num_ff || may_id_ff || sym_ff || unk_ff))
      else $error("pending length and class flags disagree");

   // An empty-line result only ever answers an end-of-line marker.
   a_none_is_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (kind_ff == KIND_NONE)) |-> (done_ff && (out_len_ff == '0)))
      else $error("no-token result without end of line");

   // The column never passes its saturation value.
   a_col_cap: assert property (@(posedge clock) disable iff (reset)
      column_ff <= COL_CAP)
      else $error("column above its limit");

endmodule
